@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the virtual clock table.
// Each macro expands to one labelled concurrent assertion clocked on clk_i, reset by rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold on every clock edge out of reset.
`define SVCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SVCT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SVCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/svct_pkg.sv @@
// Package for the scaled virtual clock table: codes, field widths and the
// controller/datapath interface structs. No dependencies.
package svct_pkg;

  // Default number of clock channels.
  localparam int NUM_CHANNELS_DEF = 16;

  // Field widths of one input beat and one result beat.
  localparam int CMD_W    = 3;
  localparam int CH_W     = 4;
  localparam int SPEED_W  = 16;
  localparam int TICK_W   = 32;
  localparam int TIME_W   = 48;
  localparam int STATUS_W = 2;

  // Packing of the stream data words (first field in the lowest bits).
  localparam int IN_CMD_LSB   = 0;
  localparam int IN_CH_LSB    = IN_CMD_LSB + CMD_W;
  localparam int IN_SPD_LSB   = IN_CH_LSB + CH_W;
  localparam int IN_NOW_LSB   = IN_SPD_LSB + SPEED_W;
  localparam int IN_BITS      = IN_NOW_LSB + TICK_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = TIME_W + STATUS_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Speed of one in Q4.12.
  localparam logic [SPEED_W-1:0] SPEED_ONE = 16'd4096;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT       = 3'd0,
    CMD_READ       = 3'd1,
    CMD_SET_SPEED  = 3'd2,
    CMD_PAUSE_ALL  = 3'd3,
    CMD_RESUME_ALL = 3'd4,
    CMD_CLEAR_ALL  = 3'd5
  } svct_cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOT_INIT = 2'd1,
    STAT_PAUSED   = 2'd2
  } svct_status_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_SUM,
    ST_SWEEP,
    ST_DONE
  } svct_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         capture;
    logic         init;
    logic         clear;
    logic         mul;
    logic         sum;
    logic         sweep;
    logic         set_status;
    svct_status_e status;
    logic         load_out;
  } svct_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_range;
    logic             ok_ch;
    logic             paused_ch;
    logic             sweep_last;
  } svct_stat_t;

endpackage

@@ hdl/svct_datapath.sv @@
// Datapath of the virtual clock table: item registers, per-channel memories and flags,
// the scaled-time multiply and saturating add, the sweep counter and the result register.
// Depends on svct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module svct_datapath import svct_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  input  svct_ctrl_t             ctrl_i,
  output svct_stat_t             stat_o,
  output logic [OUT_TDATA_W-1:0] out_tdata_o
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  // Captured input beat.
  logic [CMD_W-1:0]   cmd_q;
  logic [CH_W-1:0]    ch_q;
  logic [SPEED_W-1:0] spd_q;
  logic [TICK_W-1:0]  now_q;

  // Per-channel flags, reset at once: valid cleared, paused set.
  logic [NUM_CHANNELS-1:0] valid_q;
  logic [NUM_CHANNELS-1:0] paused_q;

  // Per-channel memories; their contents only matter once a channel is valid.
  logic [TICK_W-1:0]  pt_mem  [NUM_CHANNELS];
  logic [TICK_W-1:0]  tp_mem  [NUM_CHANNELS];
  logic [SPEED_W-1:0] spd_mem [NUM_CHANNELS];
  logic [TIME_W-1:0]  buf_mem [NUM_CHANNELS];

  logic [TICK_W-1:0]  rd_pt_q;
  logic [TICK_W-1:0]  rd_tp_q;
  logic [SPEED_W-1:0] rd_spd_q;
  logic [TIME_W-1:0]  rd_buf_q;

  // Sweep counter and the second stage of a resume sweep.
  logic [CNT_W-1:0] cnt_q;
  logic             s2_en_q;
  logic [IDX_W-1:0] s2_idx_q;

  // Arithmetic.
  logic [TICK_W-1:0] delta;
  logic [TIME_W-1:0] prod_d;
  logic [TIME_W-1:0] prod_q;
  logic [TIME_W:0]   sum_d;
  logic [TIME_W-1:0] sat_d;

  // Result and output registers.
  logic [TIME_W-1:0]      res_time_q;
  svct_status_e           res_status_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [IDX_W-1:0] ch_idx;
  logic [IDX_W-1:0] sweep_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             in_range;
  logic             sweep_in;
  logic             s1_pause;
  logic             s1_resume;
  logic             set_wr;

  logic              tp_we;
  logic [IDX_W-1:0]  tp_wa;
  logic [TICK_W-1:0] tp_wd;
  logic              pt_we;
  logic [IDX_W-1:0]  pt_wa;
  logic [TICK_W-1:0] pt_wd;

  // Capture the input beat when the controller accepts it.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= in_tdata_i[IN_CMD_LSB +: CMD_W];
      ch_q  <= in_tdata_i[IN_CH_LSB +: CH_W];
      spd_q <= in_tdata_i[IN_SPD_LSB +: SPEED_W];
      now_q <= in_tdata_i[IN_NOW_LSB +: TICK_W];
    end
  end

  // Channel and sweep indexes.
  assign ch_idx    = IDX_W'(ch_q);
  assign in_range  = (32'(ch_q) < NUM_CHANNELS);
  assign sweep_idx = cnt_q[IDX_W-1:0];
  assign sweep_in  = (32'(cnt_q) < NUM_CHANNELS);
  assign rd_addr   = ctrl_i.sweep ? sweep_idx : ch_idx;

  // Sweep actions on the entry under the counter.
  assign s1_pause  = ctrl_i.sweep && sweep_in && (cmd_q == CMD_PAUSE_ALL) &&
                     valid_q[sweep_idx] && !paused_q[sweep_idx];
  assign s1_resume = ctrl_i.sweep && sweep_in && (cmd_q == CMD_RESUME_ALL) &&
                     valid_q[sweep_idx] && paused_q[sweep_idx];

  // Sweep counter, restarted with every captured beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      s2_en_q <= 1'b0;
    end else begin
      if (ctrl_i.capture) begin
        cnt_q <= '0;
      end else if (ctrl_i.sweep && sweep_in) begin
        cnt_q <= cnt_q + 1'b1;
      end
      s2_en_q <= s1_resume;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_idx_q <= sweep_idx;
  end

  // Registered read port of every memory.
  always_ff @(posedge clk_i) begin
    rd_pt_q  <= pt_mem[rd_addr];
    rd_tp_q  <= tp_mem[rd_addr];
    rd_spd_q <= spd_mem[rd_addr];
    rd_buf_q <= buf_mem[rd_addr];
  end

  // Scaled elapsed time, registered after the multiplier.
  assign delta  = now_q - rd_tp_q;
  assign prod_d = 48'(delta) * 48'(rd_spd_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  // Buffer plus scaled time, saturated to the time width.
  assign sum_d = {1'b0, rd_buf_q} + {1'b0, prod_q};
  assign sat_d = sum_d[TIME_W] ? '1 : sum_d[TIME_W-1:0];
  assign set_wr = ctrl_i.sum && (cmd_q == CMD_SET_SPEED);

  // Write selection for the time point memory.
  always_comb begin
    tp_we = 1'b0;
    tp_wa = ch_idx;
    tp_wd = '0;
    if (ctrl_i.init) begin
      tp_we = 1'b1;
    end else if (set_wr) begin
      tp_we = 1'b1;
      tp_wd = now_q;
    end else if (s2_en_q) begin
      tp_we = 1'b1;
      tp_wa = s2_idx_q;
      tp_wd = rd_tp_q + (now_q - rd_pt_q);
    end
  end

  // Write selection for the pause tick memory.
  always_comb begin
    pt_we = 1'b0;
    pt_wa = ch_idx;
    pt_wd = '0;
    if (ctrl_i.init) begin
      pt_we = 1'b1;
    end else if (s1_pause) begin
      pt_we = 1'b1;
      pt_wa = sweep_idx;
      pt_wd = now_q;
    end
  end

  // Memory write ports.
  always_ff @(posedge clk_i) begin
    if (tp_we) begin
      tp_mem[tp_wa] <= tp_wd;
    end
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    if (ctrl_i.init) begin
      spd_mem[ch_idx] <= SPEED_ONE;
      buf_mem[ch_idx] <= '0;
    end else if (set_wr) begin
      spd_mem[ch_idx] <= spd_q;
      buf_mem[ch_idx] <= sat_d;
    end
  end

  // Valid and paused flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      paused_q <= '1;
    end else if (ctrl_i.clear) begin
      valid_q  <= '0;
      paused_q <= '1;
    end else begin
      if (ctrl_i.init) begin
        valid_q[ch_idx]  <= 1'b1;
        paused_q[ch_idx] <= 1'b0;
      end
      if (s1_pause) begin
        paused_q[sweep_idx] <= 1'b1;
      end
      if (s2_en_q) begin
        paused_q[s2_idx_q] <= 1'b0;
      end
    end
  end

  // Result being built for the current beat.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      res_time_q   <= '0;
      res_status_q <= STAT_OK;
    end else begin
      if (ctrl_i.set_status) begin
        res_status_q <= ctrl_i.status;
      end
      if (ctrl_i.sum && (cmd_q == CMD_READ)) begin
        res_time_q <= sat_d;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_data_q <= OUT_TDATA_W'({res_status_q, res_time_q});
    end
  end

  assign out_tdata_o = out_data_q;

  // Status towards the controller.
  assign stat_o.cmd        = cmd_q;
  assign stat_o.in_range   = in_range;
  assign stat_o.ok_ch      = in_range && valid_q[ch_idx];
  assign stat_o.paused_ch  = paused_q[ch_idx];
  assign stat_o.sweep_last = !sweep_in;

  // A resume write lands on an entry that is still valid and paused.
  `SVCT_ASSERT_IMPL(a_resume_target, s2_en_q, valid_q[s2_idx_q] && paused_q[s2_idx_q], "resume write on an entry that is not paused")
  // A pause step leaves its entry paused.
  `SVCT_ASSERT_NEXT(a_pause_marks, s1_pause, paused_q[$past(sweep_idx)], "paused flag not set by pause sweep")
  // Clear all leaves no channel valid.
  `SVCT_ASSERT_NEXT(a_clear_all, ctrl_i.clear, valid_q == '0, "channel still valid after clear all")

endmodule

@@ hdl/svct_ctrl.sv @@
// Controller of the virtual clock table: sequences one beat at a time through decode,
// multiply, sum or the channel sweep, and owns the handshakes. Depends on svct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module svct_ctrl import svct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  svct_stat_t stat_i,
  output svct_ctrl_t ctrl_o
);

  svct_state_e state_q;
  svct_state_e state_d;
  logic        out_valid_q;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.cmd)
          CMD_READ: begin
            if (stat_i.ok_ch && !stat_i.paused_ch) begin
              state_d = ST_MUL;
            end else begin
              state_d = ST_DONE;
            end
          end
          CMD_SET_SPEED: begin
            state_d = stat_i.ok_ch ? ST_MUL : ST_DONE;
          end
          CMD_PAUSE_ALL, CMD_RESUME_ALL: begin
            state_d = ST_SWEEP;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_MUL: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_DONE;
      end
      ST_SWEEP: begin
        if (stat_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath commands and input ready.
  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        case (stat_i.cmd)
          CMD_INIT: begin
            if (stat_i.in_range) begin
              ctrl_o.init = 1'b1;
            end else begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = STAT_NOT_INIT;
            end
          end
          CMD_READ: begin
            if (!stat_i.ok_ch) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = STAT_NOT_INIT;
            end else if (stat_i.paused_ch) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = STAT_PAUSED;
            end
          end
          CMD_SET_SPEED: begin
            if (!stat_i.ok_ch) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = STAT_NOT_INIT;
            end
          end
          CMD_CLEAR_ALL: begin
            ctrl_o.clear = 1'b1;
          end
          default: begin
            ctrl_o.clear = 1'b0;
          end
        endcase
      end
      ST_MUL: begin
        ctrl_o.mul = 1'b1;
      end
      ST_SUM: begin
        ctrl_o.sum = 1'b1;
      end
      ST_SWEEP: begin
        ctrl_o.sweep = 1'b1;
      end
      ST_DONE: begin
        ctrl_o.load_out = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // A result is only loaded when the output register is free.
  `SVCT_ASSERT_IMPL(a_load_free, ctrl_o.load_out, !out_valid_q || out_ready_i, "result loaded over a waiting beat")
  // A loaded result is offered on the next cycle.
  `SVCT_ASSERT_NEXT(a_load_shows, ctrl_o.load_out, out_valid_q, "loaded result not offered")
  // The last sweep step always hands over to the result stage.
  `SVCT_ASSERT_NEXT(a_sweep_exit, (state_q == ST_SWEEP) && stat_i.sweep_last, state_q == ST_DONE, "sweep did not finish")

endmodule

@@ hdl/scaled_virtual_clock_table.sv @@
// Scaled virtual clock table, top level: joins svct_ctrl and svct_datapath, types from svct_pkg.
// States from input beat to result beat: decode, multiply, sum and done for a read of a running valid
// channel or a set speed on a valid channel, decode, sweep and done for pause all and resume all,
// decode and done for the rest. One beat is in flight at a time, so a new beat is taken only once
// the last result is loaded; a result held back by m_axis_tready holds off the next beat as long.
// Reset (rst_ni, asynchronous, low) leaves every channel invalid and paused at once.
module scaled_virtual_clock_table import svct_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cmd[2:0], channel[6:3], new_speed[22:7], now_ms[54:23], zero pad[55]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // time_ms_q12[47:0], status[49:48], zero pad[55:50]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  svct_ctrl_t ctrl;
  svct_stat_t stat;

  // Datapath: storage and arithmetic.
  svct_datapath #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tdata_i  (s_axis_tdata),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_tdata_o (m_axis_tdata)
  );

  // Controller: sequencing and handshakes.
  svct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

endmodule
